@@ hw/rtl/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

  // Field widths.
  localparam int unsigned HueW   = 16;
  localparam int unsigned LevelW = 8;
  localparam int unsigned OffsW  = 6;

  // Hue wrapping: the signed hue is lifted by a multiple of a full turn so that
  // it is never negative, then reduced modulo a full turn.
  localparam int unsigned FullTurn  = 360;
  localparam int unsigned SectorDeg = 60;
  localparam int unsigned LiftW     = HueW + 1;
  localparam logic [LiftW-1:0] HueLift = LiftW'(92 * FullTurn);

  // Floor division of a 17-bit lifted hue by 360 through a reciprocal.
  localparam int unsigned TurnShift = 26;
  localparam int unsigned TurnMulW  = 18;
  localparam logic [TurnMulW-1:0] TurnMul =
    TurnMulW'(((64'd1 << TurnShift) + 64'd359) / 64'd360);

  // Level arithmetic: 15300 is one sector's full scale (255 * 60).
  localparam int unsigned LevelMax    = 255;
  localparam int unsigned SectorScale = LevelMax * SectorDeg;
  localparam int unsigned TermW       = 14;
  localparam int unsigned NumW        = 22;

  // Exact floor division of a 22-bit numerator by a constant through a
  // rounded-up reciprocal: shift is numerator width plus ceil(log2(divisor)).
  localparam int unsigned RecipW       = 23;
  localparam int unsigned Div255Shift  = NumW + 8;
  localparam int unsigned DivSecShift  = NumW + 14;
  localparam logic [RecipW-1:0] Div255Mul =
    RecipW'(((64'd1 << Div255Shift) + 64'd254) / 64'd255);
  localparam logic [RecipW-1:0] DivSecMul =
    RecipW'(((64'd1 << DivSecShift) + 64'd15299) / 64'd15300);
  localparam int unsigned ProdW = NumW + RecipW;

  // Request latency from acceptance to the result strobe.
  localparam int unsigned Latency = 7;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e             sector;
    logic [OffsW-1:0]    offs;
    logic [LevelW-1:0]   sat;
    logic [LevelW-1:0]   val;
  } split_t;

endpackage

@@ hw/rtl/hsv2rgb_hue_split.sv @@
module hsv2rgb_hue_split import hsv2rgb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [HueW-1:0]   hue_i,
  input  logic [LevelW-1:0]        sat_i,
  input  logic [LevelW-1:0]        val_i,
  output logic                     valid_o,
  output split_t                   split_o
);

  localparam int unsigned QuotW = 8;

  // Stage A: lift and reciprocal quotient.
  logic [2:0]                valid_q;
  logic [LiftW-1:0]          lift_d, lift_q;
  logic [QuotW-1:0]          quot_d, quot_q;
  logic [LiftW+TurnMulW-1:0] quot_prod;
  logic [LevelW-1:0]         sat_a_q, val_a_q, sat_b_q, val_b_q;

  // Stage B: wrapped hue.
  logic [LiftW-1:0]          rem_full;
  logic [8:0]                hue_d, hue_q;

  // Stage C: sector and offset.
  sector_e                   sector_d;
  logic [8:0]                base;
  logic [8:0]                offs_full;
  split_t                    split_d, split_q;

  assign lift_d    = LiftW'({hue_i[HueW-1], hue_i}) + HueLift;
  assign quot_prod = LiftW'(lift_d) * TurnMul;
  assign quot_d    = quot_prod[TurnShift +: QuotW];

  assign rem_full = lift_q - LiftW'(quot_q * LiftW'(FullTurn));
  assign hue_d    = rem_full[8:0];

  always_comb begin
    if (hue_q < 9'd60) begin
      sector_d = SEC_RED_YEL;
      base     = 9'd0;
    end else if (hue_q < 9'd120) begin
      sector_d = SEC_YEL_GRN;
      base     = 9'd60;
    end else if (hue_q < 9'd180) begin
      sector_d = SEC_GRN_CYN;
      base     = 9'd120;
    end else if (hue_q < 9'd240) begin
      sector_d = SEC_CYN_BLU;
      base     = 9'd180;
    end else if (hue_q < 9'd300) begin
      sector_d = SEC_BLU_MAG;
      base     = 9'd240;
    end else begin
      sector_d = SEC_MAG_RED;
      base     = 9'd300;
    end
    offs_full      = hue_q - base;
    split_d.sector = sector_d;
    split_d.offs   = offs_full[OffsW-1:0];
    split_d.sat    = sat_b_q;
    split_d.val    = val_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    lift_q  <= lift_d;
    quot_q  <= quot_d;
    sat_a_q <= sat_i;
    val_a_q <= val_i;
    hue_q   <= hue_d;
    sat_b_q <= sat_a_q;
    val_b_q <= val_a_q;
    split_q <= split_d;
  end

  assign valid_o = valid_q[2];
  assign split_o = split_q;

  // The wrapped hue must always land inside one full turn.
  a_hue_in_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> hue_q < 9'd360)
    else $error("wrapped hue outside one turn");

  a_offs_in_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> split_o.offs < OffsW'(SectorDeg))
    else $error("sector offset out of range");

  a_lift_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> lift_q >= LiftW'(352))
    else $error("lifted hue below expected minimum");

endmodule

@@ hw/rtl/hsv_to_rgb_converter.sv @@
// Channel   Direction  Handshake                Payload
// request   in         start_i && !busy_o       hue_degrees_i, saturation_i, brightness_i
// result    out        valid_o (one-cycle)      red_level_o, green_level_o, blue_level_o
//
// One request is taken in every cycle; busy_o never rises.
// The datapath has seven register stages between acceptance and the result (lift and
// quotient, hue wrap, sector split, terms, products, divide, select).
// Reset clears only the valid bits of the pipeline; payload registers are not reset.
// The receiver cannot stall, so nothing is ever held back inside the pipeline.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [HueW-1:0]  hue_degrees_i,
  input  logic [LevelW-1:0]       saturation_i,
  input  logic [LevelW-1:0]       brightness_i,
  output logic                    valid_o,
  output logic [LevelW-1:0]       red_level_o,
  output logic [LevelW-1:0]       green_level_o,
  output logic [LevelW-1:0]       blue_level_o
);

  // Every cycle is free to accept a request since the pipeline never stalls.
  logic   accept;
  logic   split_valid;
  split_t split;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // The first three stages wrap the hue and break it into sector and offset.
  hsv2rgb_hue_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .hue_i   (hue_degrees_i),
    .sat_i   (saturation_i),
    .val_i   (brightness_i),
    .valid_o (split_valid),
    .split_o (split)
  );

  // Stage D: the three subtractive terms. The first scales by 255, the other
  // two by a full sector scale of 15300 (255 * 60).
  logic [3:0]          valid_q;
  logic [TermW-1:0]    sat_offs, sat_rest;
  logic [OffsW-1:0]    rest;
  logic [LevelW-1:0]   t1_d, t1_q;
  logic [TermW-1:0]    t2_d, t2_q, t3_d, t3_q;
  sector_e             sector_d_q, sector_e_q, sector_f_q;
  logic [LevelW-1:0]   val_d_q, val_e_q, val_f_q;
  logic                grey_d_q, grey_e_q, grey_f_q;

  assign rest     = OffsW'(SectorDeg) - split.offs;
  assign sat_offs = TermW'(split.sat) * TermW'(split.offs);
  assign sat_rest = TermW'(split.sat) * TermW'(rest);
  assign t1_d     = LevelW'(LevelMax) - split.sat;
  assign t2_d     = TermW'(SectorScale) - sat_offs;
  assign t3_d     = TermW'(SectorScale) - sat_rest;

  // Stage E: numerators, biased by divisor minus one so that the floor
  // division that follows rounds the quotient up.
  logic [NumW-1:0] n1_d, n1_q, n2_d, n2_q, n3_d, n3_q;

  assign n1_d = NumW'(val_d_q) * NumW'(t1_q) + NumW'(LevelMax - 1);
  assign n2_d = NumW'(val_d_q) * NumW'(t2_q) + NumW'(SectorScale - 1);
  assign n3_d = NumW'(val_d_q) * NumW'(t3_q) + NumW'(SectorScale - 1);

  // Stage F: divide by constants through exact rounded-up reciprocals. Every
  // quotient is at most the brightness, so eight bits always hold it.
  logic [ProdW-1:0]  p1, p2, p3;
  logic [LevelW-1:0] c1_d, c1_q, c2_d, c2_q, c3_d, c3_q;

  assign p1   = ProdW'(n1_q) * ProdW'(Div255Mul);
  assign p2   = ProdW'(n2_q) * ProdW'(DivSecMul);
  assign p3   = ProdW'(n3_q) * ProdW'(DivSecMul);
  assign c1_d = p1[Div255Shift +: LevelW];
  assign c2_d = p2[DivSecShift +: LevelW];
  assign c3_d = p3[DivSecShift +: LevelW];

  // Stage G: place the levels by sector. Grey input bypasses the terms so all
  // three channels carry the brightness.
  logic [LevelW-1:0] red_d, green_d, blue_d;
  logic [LevelW-1:0] red_q, green_q, blue_q;

  always_comb begin
    case (sector_f_q)
      SEC_RED_YEL: begin
        red_d = val_f_q;  green_d = c3_q;    blue_d = c1_q;
      end
      SEC_YEL_GRN: begin
        red_d = c2_q;     green_d = val_f_q; blue_d = c1_q;
      end
      SEC_GRN_CYN: begin
        red_d = c1_q;     green_d = val_f_q; blue_d = c3_q;
      end
      SEC_CYN_BLU: begin
        red_d = c1_q;     green_d = c2_q;    blue_d = val_f_q;
      end
      SEC_BLU_MAG: begin
        red_d = c3_q;     green_d = c1_q;    blue_d = val_f_q;
      end
      default: begin
        red_d = val_f_q;  green_d = c1_q;    blue_d = c2_q;
      end
    endcase
    if (grey_f_q) begin
      red_d   = val_f_q;
      green_d = val_f_q;
      blue_d  = val_f_q;
    end
  end

  // Only the valid bits are reset; they alone decide what reaches the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], split_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q       <= t1_d;
    t2_q       <= t2_d;
    t3_q       <= t3_d;
    sector_d_q <= split.sector;
    val_d_q    <= split.val;
    grey_d_q   <= (split.sat == '0);
    n1_q       <= n1_d;
    n2_q       <= n2_d;
    n3_q       <= n3_d;
    sector_e_q <= sector_d_q;
    val_e_q    <= val_d_q;
    grey_e_q   <= grey_d_q;
    c1_q       <= c1_d;
    c2_q       <= c2_d;
    c3_q       <= c3_d;
    sector_f_q <= sector_e_q;
    val_f_q    <= val_e_q;
    grey_f_q   <= grey_e_q;
    red_q      <= red_d;
    green_q    <= green_d;
    blue_q     <= blue_d;
  end

  assign valid_o       = valid_q[3];
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;

  // A result strobe must trace back to exactly one accepted request.
  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, Latency))
    else $error("result without a matching request");

  // Grey input yields three equal channels.
  a_grey_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(saturation_i, Latency) == '0) |->
      (red_level_o == green_level_o && green_level_o == blue_level_o))
    else $error("grey input gave unequal channels");

  // No channel may exceed the brightness, and one channel always reaches it.
  a_levels_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (red_level_o <= $past(brightness_i, Latency) &&
                 green_level_o <= $past(brightness_i, Latency) &&
                 blue_level_o <= $past(brightness_i, Latency)))
    else $error("channel above brightness");

  a_level_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (red_level_o == $past(brightness_i, Latency) ||
                 green_level_o == $past(brightness_i, Latency) ||
                 blue_level_o == $past(brightness_i, Latency)))
    else $error("no channel at brightness");

endmodule
